// ===== hw/rtl/wlmsd_pkg.sv =====
`timescale 1ns / 1ps
package wlmsd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COORD_W = 11;
  localparam int CFG_W = 12;
  localparam int HALF_W = 3;
  localparam int ROW_LIMIT = 2048;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [HALF_W-1:0] HALF_RESET = 3'd2;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_HALF_WINDOW  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] response;
    logic                       frame_start;
  } pixel_t;

  typedef struct packed {
    logic               seed;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
  } result_t;

  typedef struct packed {
    logic               decide;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
  } site_t;

endpackage

// ===== hw/rtl/wlmsd_front.sv =====
`timescale 1ns / 1ps
module wlmsd_front #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HALF_WINDOW = 7
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        pixel_valid,
  output logic                                        pixel_stall,
  input  wlmsd_pkg::pixel_t                           pixel,
  input  logic [$clog2(MAX_WIDTH):0]                  eff_w,
  input  logic [wlmsd_pkg::CFG_W-1:0]                 eff_h,
  input  logic [$clog2(MAX_HALF_WINDOW+1)-1:0]        hw,
  output logic                                        push_valid,
  input  logic                                        push_ready,
  output logic [2*MAX_HALF_WINDOW:0][wlmsd_pkg::SAMPLE_W-1:0] col_out,
  output logic [$clog2(2*MAX_HALF_WINDOW+1)-1:0]      ptr_out,
  output wlmsd_pkg::site_t                            site_out
);
  localparam int NB = 2 * MAX_HALF_WINDOW + 1;
  localparam int PW = $clog2(NB);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = CW + 1;
  localparam int LW = (EW > wlmsd_pkg::CFG_W) ? EW : wlmsd_pkg::CFG_W;
  localparam int HW = $clog2(MAX_HALF_WINDOW + 1);
  localparam int SW = wlmsd_pkg::SAMPLE_W;
  localparam int RW = wlmsd_pkg::COORD_W;
  localparam int HTW = wlmsd_pkg::CFG_W;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [PW-1:0] ptr;
  logic [CW-1:0] c;
  logic [RW-1:0] r;
  logic [PW-1:0] p;
  logic          accept;
  logic [EW-1:0] c1;
  logic [HTW-1:0] r1;
  logic [HW+1:0] span;
  logic          decide;
  logic [LW-1:0] cx_wide;
  logic          f1_valid;
  logic [SW-1:0] f1_pix;
  logic [PW-1:0] f1_ptr;
  wlmsd_pkg::site_t f1_site;

  assign pixel_stall = f1_valid && !push_ready;
  assign accept = pixel_valid && !pixel_stall;

  assign c = pixel.frame_start ? '0 : col;
  assign r = pixel.frame_start ? '0 : row;
  assign p = pixel.frame_start ? '0 : ptr;
  assign c1 = {1'b0, c} + EW'(1);
  assign r1 = {1'b0, r} + HTW'(1);
  assign span = {1'b0, hw, 1'b1};

  assign decide = (LW'(c) >= LW'(span)) && (LW'(c1) < LW'(eff_w)) &&
                  (HTW'(r) >= HTW'(span)) && (r1 < eff_h);
  assign cx_wide = LW'(c) - LW'(hw);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      ptr <= '0;
    end else if (accept) begin
      if (c1 >= eff_w) begin
        col <= '0;
        if (r1 >= eff_h) begin
          row <= '0;
          ptr <= '0;
        end else begin
          row <= r1[RW-1:0];
          ptr <= (p == PW'(NB - 1)) ? '0 : p + PW'(1);
        end
      end else begin
        col <= c1[CW-1:0];
        row <= r;
        ptr <= p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (accept) begin
      f1_valid <= 1'b1;
    end else if (push_ready) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_pix <= pixel.response;
      f1_ptr <= p;
      f1_site.decide <= decide;
      f1_site.pixel_col <= cx_wide[RW-1:0];
      f1_site.pixel_row <= r - RW'(hw);
    end
  end

  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic [SW-1:0] store [MAX_WIDTH];
    logic [SW-1:0] rd;
    always_ff @(posedge clk) begin
      if (accept && p == PW'(b)) begin
        store[c] <= pixel.response;
      end
      if (accept) begin
        rd <= store[c];
      end
    end
    // The bank being written this pixel still reads its old contents.
    assign col_out[b] = (f1_ptr == PW'(b)) ? f1_pix : rd;
  end

  assign push_valid = f1_valid;
  assign ptr_out = f1_ptr;
  assign site_out = f1_site;

endmodule

// ===== hw/rtl/wlmsd_queue.sv =====
`timescale 1ns / 1ps
module wlmsd_queue #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] slots [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign push_ready = count != (AW + 1)'(DEPTH);
  assign pop_valid = count != '0;
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_data = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW + 1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/wlmsd_back.sv =====
`timescale 1ns / 1ps
module wlmsd_back #(
  parameter int MAX_HALF_WINDOW = 7
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                pop_valid,
  output logic                                                pop_ready,
  input  logic [2*MAX_HALF_WINDOW:0][wlmsd_pkg::SAMPLE_W-1:0] col_in,
  input  logic [$clog2(2*MAX_HALF_WINDOW+1)-1:0]              ptr_in,
  input  wlmsd_pkg::site_t                                    site_in,
  input  logic [$clog2(MAX_HALF_WINDOW+1)-1:0]                hw,
  output logic                                                result_valid,
  input  logic                                                result_stall,
  output wlmsd_pkg::result_t                                  result
);
  localparam int NB = 2 * MAX_HALF_WINDOW + 1;
  localparam int PW = $clog2(NB);
  localparam int SW = wlmsd_pkg::SAMPLE_W;

  logic advance;
  logic pop;
  logic [NB-1:0][NB-1:0][SW-1:0] win;
  logic [NB-1:0][NB-1:0][SW-1:0] win_next;
  logic [PW:0]   cbank;
  logic [PW-1:0] hw_idx;
  logic [PW:0]   hw_ext;
  logic [PW:0]   span2;
  logic signed [SW-1:0] center;
  logic [PW:0]   row_dist [NB];
  logic [NB*NB-1:0] ok_next;
  logic          s1_valid;
  logic [NB*NB-1:0] s1_ok;
  logic          s1_pos;
  wlmsd_pkg::site_t s1_site;

  assign advance = !result_valid || !result_stall;
  assign pop_ready = advance;
  assign pop = pop_valid && advance;

  assign hw_idx = PW'(hw);
  assign hw_ext = (PW + 1)'(hw);
  assign span2 = (PW + 1)'({hw, 1'b0});
  assign cbank = ({1'b0, ptr_in} >= hw_ext) ? {1'b0, ptr_in} - hw_ext
                                            : {1'b0, ptr_in} + (PW + 1)'(NB) - hw_ext;

  always_comb begin
    win_next[0] = col_in;
    for (int j = 1; j < NB; j++) begin
      win_next[j] = win[j-1];
    end
  end

  assign center = win_next[hw_idx][cbank[PW-1:0]];

  // Window bank b holds the row that lies row_dist[b] rows above the newest one.
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      if (ptr_in >= PW'(b)) begin
        row_dist[b] = {1'b0, ptr_in} - (PW + 1)'(b);
      end else begin
        row_dist[b] = {1'b0, ptr_in} + (PW + 1)'(NB) - (PW + 1)'(b);
      end
    end
    for (int j = 0; j < NB; j++) begin
      for (int b = 0; b < NB; b++) begin
        ok_next[j*NB+b] = !((row_dist[b] <= span2) && ((PW + 1)'(j) <= span2)) ||
                          ((row_dist[b] == hw_ext) && ((PW + 1)'(j) == hw_ext)) ||
                          (center > $signed(win_next[j][b]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= pop && site_in.decide;
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ok <= ok_next;
      s1_pos <= center > $signed(SW'(0));
      s1_site <= site_in;
      result.seed <= s1_pos && (&s1_ok);
      result.pixel_col <= s1_site.pixel_col;
      result.pixel_row <= s1_site.pixel_row;
    end
  end

endmodule

// ===== hw/rtl/window_local_maximum_seed_detector.sv =====
`timescale 1ns / 1ps
// A decided pixel's word passes the front register, the queue, the compare and the result registers
// after the edge that accepts the pixel completing its window, and is held back while the output stalls.
// Throughput: one pixel per clock while pixel_stall is low, set by one read of every row memory bank per pixel.
// Row memories hold 2*MAX_HALF_WINDOW+1 rows of MAX_WIDTH samples; the window compare is one stage.
// Reset clears the position counters, the pipeline and restores the register defaults.
// Row memory contents are not cleared by reset.
module window_local_maximum_seed_detector #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HALF_WINDOW = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  wlmsd_pkg::pixel_t             pixel,
  output logic                          result_valid,
  input  logic                          result_stall,
  output wlmsd_pkg::result_t            result,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [wlmsd_pkg::CFG_W-1:0]   cfg_data
);
  localparam int NB = 2 * MAX_HALF_WINDOW + 1;
  localparam int PW = $clog2(NB);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = CW + 1;
  localparam int LW = (EW > wlmsd_pkg::CFG_W) ? EW : wlmsd_pkg::CFG_W;
  localparam int HW = $clog2(MAX_HALF_WINDOW + 1);
  localparam int HCW = (HW > wlmsd_pkg::HALF_W) ? HW : wlmsd_pkg::HALF_W;
  localparam int SW = wlmsd_pkg::SAMPLE_W;
  localparam int HTW = wlmsd_pkg::CFG_W;
  localparam int SITE_W = $bits(wlmsd_pkg::site_t);
  localparam int COL_W = NB * SW;
  localparam int QW = SITE_W + PW + COL_W;

  logic [HTW-1:0] frame_width;
  logic [HTW-1:0] frame_height;
  logic [wlmsd_pkg::HALF_W-1:0] half_window;
  logic [EW-1:0]  eff_w;
  logic [HTW-1:0] eff_h;
  logic [HW-1:0]  hw;
  logic [LW-1:0]  fw_ext;

  logic push_valid;
  logic push_ready;
  logic [NB-1:0][SW-1:0] front_col;
  logic [PW-1:0] front_ptr;
  wlmsd_pkg::site_t front_site;
  logic pop_valid;
  logic pop_ready;
  logic [QW-1:0] push_data;
  logic [QW-1:0] pop_data;
  logic [NB-1:0][SW-1:0] back_col;
  logic [PW-1:0] back_ptr;
  wlmsd_pkg::site_t back_site;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= wlmsd_pkg::WIDTH_RESET;
      frame_height <= wlmsd_pkg::HEIGHT_RESET;
      half_window <= wlmsd_pkg::HALF_RESET;
    end else if (cfg_we) begin
      if (cfg_index == wlmsd_pkg::REG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end
      if (cfg_index == wlmsd_pkg::REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
      end
      if (cfg_index == wlmsd_pkg::REG_HALF_WINDOW) begin
        half_window <= cfg_data[wlmsd_pkg::HALF_W-1:0];
      end
    end
  end

  assign fw_ext = LW'(frame_width);

  always_comb begin
    if (frame_width == '0) begin
      eff_w = EW'(1);
    end else if (fw_ext > LW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext[EW-1:0];
    end
    if (frame_height == '0) begin
      eff_h = HTW'(1);
    end else if (frame_height > HTW'(wlmsd_pkg::ROW_LIMIT)) begin
      eff_h = HTW'(wlmsd_pkg::ROW_LIMIT);
    end else begin
      eff_h = frame_height;
    end
    if (HCW'(half_window) > HCW'(MAX_HALF_WINDOW)) begin
      hw = HW'(MAX_HALF_WINDOW);
    end else begin
      hw = HW'(half_window);
    end
  end

  wlmsd_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel(pixel),
    .eff_w(eff_w),
    .eff_h(eff_h),
    .hw(hw),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .col_out(front_col),
    .ptr_out(front_ptr),
    .site_out(front_site)
  );

  assign push_data = {front_site, front_ptr, front_col};

  wlmsd_queue #(
    .W(QW),
    .DEPTH(4)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data(push_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data(pop_data)
  );

  assign back_col = pop_data[COL_W-1:0];
  assign back_ptr = pop_data[COL_W+PW-1:COL_W];
  assign back_site = pop_data[QW-1:COL_W+PW];

  wlmsd_back #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .col_in(back_col),
    .ptr_in(back_ptr),
    .site_in(back_site),
    .hw(hw),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

endmodule
